>>> sv/msf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the midi sysex store-and-forward block
package msf_pkg;

    localparam logic [7:0]  BYTE_START    = 8'hF0;
    localparam logic [7:0]  BYTE_END      = 8'hF7;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
    localparam int          ELAPSED_W     = 17;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int         PADDR_W     = 3;
    localparam logic       REG_TIMEOUT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } msf_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic load_pass;
        logic load_msg;
        logic msg_last;
    } msf_cmd_t;

    typedef struct packed {
        logic out_free;
    } msf_status_t;

endpackage

>>> sv/msf_datapath.sv
`timescale 1ns / 1ps
// message store memory and result output register
module msf_datapath #(
    parameter int STORE_DEPTH = 64,
    parameter int ADDR_W      = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  msf_pkg::msf_cmd_t   cmd,
    output msf_pkg::msf_status_t status,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [ADDR_W-1:0]   rd_addr,
    input  logic [7:0]          s_data_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_from_message,
    output logic                m_last
);
    import msf_pkg::*;

    logic [7:0] store_mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] out_byte_reg;
    logic       from_message_reg;
    logic       last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            store_mem[wr_addr] <= s_data_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_pass || cmd.load_msg) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pass) begin
            out_byte_reg     <= s_data_byte;
            from_message_reg <= 1'b0;
            last_reg         <= 1'b1;
        end else if (cmd.load_msg) begin
            out_byte_reg     <= rd_data_reg;
            from_message_reg <= 1'b1;
            last_reg         <= cmd.msg_last;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_out_byte      = out_byte_reg;
    assign m_from_message  = from_message_reg;
    assign m_last          = last_reg;

endmodule

>>> sv/msf_ctrl.sv
`timescale 1ns / 1ps
// controller: message state, fill count, tick timeout and release sequencing
module msf_ctrl #(
    parameter int STORE_DEPTH = 64,
    parameter int ADDR_W      = 6,
    parameter int CNT_W       = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [7:0]           s_data_byte,
    input  logic [15:0]          timeout_ticks,
    input  msf_pkg::msf_status_t status,
    output msf_pkg::msf_cmd_t    cmd,
    output logic [ADDR_W-1:0]    wr_addr,
    output logic [ADDR_W-1:0]    rd_addr
);
    import msf_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

    msf_state_t             state_reg;
    msf_state_t             state_next;
    logic                   in_msg_reg;
    logic                   in_msg_next;
    logic [CNT_W-1:0]       fill_reg;
    logic [CNT_W-1:0]       fill_next;
    logic [ELAPSED_W-1:0]   elapsed_reg;
    logic [ELAPSED_W-1:0]   elapsed_next;
    logic [ELAPSED_W-1:0]   elapsed_inc;
    logic [ADDR_W-1:0]      rd_idx_reg;
    logic [ADDR_W-1:0]      rd_idx_next;
    logic                   accept;
    logic                   is_start;
    logic                   is_end;
    logic                   msg_active;
    logic [CNT_W-1:0]       fill_eff;
    logic                   store_ok;
    logic                   release_last;

    assign s_ready      = (state_reg == ST_IDLE) && status.out_free;
    assign accept       = s_valid && s_ready;
    assign is_start     = (s_data_byte == BYTE_START);
    assign is_end       = (s_data_byte == BYTE_END);
    assign msg_active   = is_start || in_msg_reg;
    assign fill_eff     = is_start ? '0 : fill_reg;
    assign store_ok     = accept && (s_op == OP_DATA) && msg_active && (fill_eff != DEPTH_CNT);
    assign elapsed_inc  = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign release_last = (CNT_W'(rd_idx_reg) + 1'b1) == fill_reg;
    assign wr_addr      = fill_eff[ADDR_W-1:0];
    assign rd_addr      = rd_idx_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (store_ok && is_end) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (status.out_free) begin
                    state_next = release_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.wr_en     = store_ok;
                cmd.load_pass = accept && (s_op == OP_DATA) && !msg_active;
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
            end
            ST_SEND: begin
                cmd.load_msg = status.out_free;
                cmd.msg_last = release_last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // message bookkeeping
    always_comb begin
        in_msg_next  = in_msg_reg;
        fill_next    = fill_reg;
        elapsed_next = elapsed_reg;
        rd_idx_next  = rd_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op == OP_TICK)) begin
                    if (in_msg_reg) begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc > {1'b0, timeout_ticks}) begin
                            in_msg_next = 1'b0;
                            fill_next   = '0;
                        end
                    end
                end else if (accept && msg_active) begin
                    if (is_start) begin
                        elapsed_next = '0;
                    end
                    if (fill_eff == DEPTH_CNT) begin
                        in_msg_next = 1'b0;
                        fill_next   = '0;
                    end else begin
                        in_msg_next = 1'b1;
                        fill_next   = fill_eff + 1'b1;
                        rd_idx_next = '0;
                    end
                end
            end
            ST_READ: begin
            end
            ST_SEND: begin
                if (status.out_free) begin
                    if (release_last) begin
                        in_msg_next = 1'b0;
                        fill_next   = '0;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_msg_reg  <= 1'b0;
            fill_reg    <= '0;
            elapsed_reg <= '0;
            rd_idx_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            in_msg_reg  <= in_msg_next;
            fill_reg    <= fill_next;
            elapsed_reg <= elapsed_next;
            rd_idx_reg  <= rd_idx_next;
        end
    end

endmodule

>>> sv/midi_sysex_store_forward.sv
`timescale 1ns / 1ps
// MIDI SysEx store-and-forward buffer, top level. Each input transaction is a MIDI byte or a
// millisecond tick. Ticks, bytes outside a message and bytes stored into a message are taken
// in one cycle each, back to back, while the output register is free or being emptied. When
// 0xF7 closes a message the stored bytes are released one by one, each as a registered
// read of the message store, then a load of the output register once it is free, and the
// input stays stalled until the last stored byte has been loaded. The timeout
// register sits at byte address 0 of the APB port and resets to 2000 ticks.
module midi_sysex_store_forward #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [7:0]                   s_data_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_out_byte,
    output logic                         m_from_message,
    output logic                         m_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msf_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import msf_pkg::*;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

    logic [15:0]       timeout_reg;
    logic              reg_sel;
    msf_cmd_t          cmd;
    msf_status_t       status;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_TIMEOUT);
    assign prdata  = reg_sel ? {16'd0, timeout_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            timeout_reg <= pwdata[15:0];
        end
    end

    msf_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_data_byte   (s_data_byte),
        .timeout_ticks (timeout_reg),
        .status        (status),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr)
    );

    msf_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .wr_addr        (wr_addr),
        .rd_addr        (rd_addr),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_from_message (m_from_message),
        .m_last         (m_last)
    );

endmodule
